// ===== hw/rtl/kvt_pkg.sv =====
// kvt_pkg: shared codes, defaults and types for the key/value table
// used by kvt_cell and key_value_table_newest_first_unit; no dependencies
`default_nettype none

package kvt_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int VALUE_BITS_DEFAULT = 64;
	localparam int KEY_BITS           = 32;
	localparam int PORT_VALUE_BITS    = 64;

	// command codes
	localparam logic [1:0] CMD_INSERT     = 2'd0;
	localparam logic [1:0] CMD_INSERT_NEW = 2'd1;
	localparam logic [1:0] CMD_LOOKUP     = 2'd2;
	localparam logic [1:0] CMD_REMOVE     = 2'd3;

	// status codes
	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_NONE = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// row-wide update strobes sent to every cell
	typedef struct packed {
		logic push;   // shift one cell back, new entry into cell 0
		logic pull;   // close the gap at the newest match
	} kvt_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kvt_cell.sv =====
// kvt_cell: one slot of the newest-first table, key/value/occupied plus compare
// depends on kvt_pkg for key width and the control struct
`default_nettype none

module kvt_cell #(
	parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEFAULT
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cmp_en,
	input  wire [kvt_pkg::KEY_BITS-1:0]      cmp_key,
	input  wire kvt_pkg::kvt_ctrl_t          ctrl,
	input  wire [kvt_pkg::KEY_BITS-1:0]      prev_key,
	input  wire [VALUE_BITS-1:0]             prev_val,
	input  wire                              prev_occ,
	input  wire [kvt_pkg::KEY_BITS-1:0]      next_key,
	input  wire [VALUE_BITS-1:0]             next_val,
	input  wire                              next_occ,
	input  wire                              hit_in,
	output logic                             hit_out,
	input  wire [VALUE_BITS-1:0]             vsel_in,
	output logic [VALUE_BITS-1:0]            vsel_out,
	output logic [kvt_pkg::KEY_BITS-1:0]     key_q,
	output logic [VALUE_BITS-1:0]            val_q,
	output logic                             occ_q
);

	logic match_q;
	logic sel;
	logic shift_fwd;

	// newest match is the first occupied match down the row
	assign sel       = occ_q & match_q & ~hit_in;
	assign hit_out   = hit_in | (occ_q & match_q);
	assign vsel_out  = vsel_in | (sel ? val_q : '0);
	assign shift_fwd = ctrl.pull & (hit_in | sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.push) begin
			occ_q <= prev_occ;
		end else if (shift_fwd) begin
			occ_q <= next_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_q <= (key_q == cmp_key);
		end
		if (ctrl.push) begin
			key_q <= prev_key;
			val_q <= prev_val;
		end else if (shift_fwd) begin
			key_q <= next_key;
			val_q <= next_val;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/key_value_table_newest_first_unit.sv =====
// key_value_table_newest_first_unit: newest-first associative key/value table
// built as a row of kvt_cell slots; depends on kvt_pkg and kvt_cell
// the command word waits in the command stage while every cell compares its key, then
//   executes into the result register once that register is free or being drained
// one command in flight: the next command word is taken only after the compare in every
//   cell and the update that walks the hit chain and shifts the row
// reset: arst_n clears the occupancy of every cell (table empty) and the handshakes;
//   key and value contents are not cleared
`default_nettype none

module key_value_table_newest_first_unit #(
	parameter int DEPTH      = kvt_pkg::DEPTH_DEFAULT,
	parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEFAULT
) (
	input  wire          clk,
	input  wire          arst_n,
	// command side
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [95:0]  s_tdata,   // key [31:0], value_in [95:32]
	input  wire  [1:0]   s_tuser,   // command [1:0]
	// result side
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [63:0]  m_tdata,   // value_out [63:0]
	output logic [2:0]   m_tuser    // found [0], status [2:1]
);

	localparam int KB = kvt_pkg::KEY_BITS;

	// command stage: holds the word while every cell compares its key
	logic                  op_valid_s1;
	logic [1:0]            op_cmd_s1;
	logic [KB-1:0]         op_key_s1;
	logic [VALUE_BITS-1:0] op_val_s1;

	// result register
	logic                  m_tvalid_q;
	logic [63:0]           m_tdata_q;
	logic [2:0]            m_tuser_q;

	logic                  accept;
	logic                  exec;
	logic                  hit;
	logic                  full;
	logic [1:0]            status;
	kvt_pkg::kvt_ctrl_t    ctrl;

	// row wiring
	logic [KB-1:0]         key_w  [DEPTH];
	logic [VALUE_BITS-1:0] val_w  [DEPTH];
	logic [DEPTH-1:0]      occ_vec;
	logic [DEPTH:0]        hit_chain;
	logic [VALUE_BITS-1:0] vsel_chain [DEPTH+1];

	// one command in flight: a new word is taken once the previous one has executed
	assign s_tready = ~op_valid_s1;
	assign accept   = s_tvalid & s_tready;
	// the update happens only when the result register is free or being drained
	assign exec     = op_valid_s1 & (~m_tvalid_q | m_tready);

	assign hit  = hit_chain[DEPTH];
	assign full = occ_vec[DEPTH-1];

	assign hit_chain[0]  = 1'b0;
	assign vsel_chain[0] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (accept) begin
			op_valid_s1 <= 1'b1;
		end else if (exec) begin
			op_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_cmd_s1 <= s_tuser;
			op_key_s1 <= s_tdata[31:0];
			op_val_s1 <= s_tdata[32 +: VALUE_BITS];
		end
	end

	// decide the row update and the status from the hit chain and the fill state
	always_comb begin
		ctrl.push = 1'b0;
		ctrl.pull = 1'b0;
		status    = kvt_pkg::STATUS_DONE;
		case (op_cmd_s1)
			kvt_pkg::CMD_INSERT: begin
				if (full) begin
					status = kvt_pkg::STATUS_FULL;
				end else begin
					ctrl.push = exec;
				end
			end
			kvt_pkg::CMD_INSERT_NEW: begin
				if (hit) begin
					status = kvt_pkg::STATUS_NONE;
				end else if (full) begin
					status = kvt_pkg::STATUS_FULL;
				end else begin
					ctrl.push = exec;
				end
			end
			kvt_pkg::CMD_LOOKUP: begin
				if (!hit) begin
					status = kvt_pkg::STATUS_NONE;
				end
			end
			kvt_pkg::CMD_REMOVE: begin
				if (hit) begin
					ctrl.pull = exec;
				end else begin
					status = kvt_pkg::STATUS_NONE;
				end
			end
			default: begin
				status = kvt_pkg::STATUS_NONE;
			end
		endcase
	end

	// the cell row: each slot hands its entry to the neighbor behind on insert
	// and takes the one behind it on remove at or past the newest match
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KB-1:0]         prev_key;
		logic [VALUE_BITS-1:0] prev_val;
		logic                  prev_occ;
		logic [KB-1:0]         next_key;
		logic [VALUE_BITS-1:0] next_val;
		logic                  next_occ;

		if (i == 0) begin : g_head
			assign prev_key = op_key_s1;
			assign prev_val = op_val_s1;
			assign prev_occ = 1'b1;
		end else begin : g_body
			assign prev_key = key_w[i-1];
			assign prev_val = val_w[i-1];
			assign prev_occ = occ_vec[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign next_key = '0;
			assign next_val = '0;
			assign next_occ = 1'b0;
		end else begin : g_inner
			assign next_key = key_w[i+1];
			assign next_val = val_w[i+1];
			assign next_occ = occ_vec[i+1];
		end

		kvt_cell #(
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmp_en   (accept),
			.cmp_key  (s_tdata[31:0]),
			.ctrl     (ctrl),
			.prev_key (prev_key),
			.prev_val (prev_val),
			.prev_occ (prev_occ),
			.next_key (next_key),
			.next_val (next_val),
			.next_occ (next_occ),
			.hit_in   (hit_chain[i]),
			.hit_out  (hit_chain[i+1]),
			.vsel_in  (vsel_chain[i]),
			.vsel_out (vsel_chain[i+1]),
			.key_q    (key_w[i]),
			.val_q    (val_w[i]),
			.occ_q    (occ_vec[i])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			// only a lookup returns the matched value word
			if (op_cmd_s1 == kvt_pkg::CMD_LOOKUP) begin
				m_tdata_q <= kvt_pkg::PORT_VALUE_BITS'(vsel_chain[DEPTH]);
			end else begin
				m_tdata_q <= '0;
			end
			m_tuser_q <= {status, hit};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// a command never both inserts and removes
	a_push_pull_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.push && ctrl.pull))
		else $error("insert and remove strobes both high");

	// occupied cells always form a block at the front of the row
	a_occ_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_vec & (occ_vec + DEPTH'(1))) == '0)
		else $error("occupancy has a gap");

	// a fresh result only follows an executing command
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(op_valid_s1))
		else $error("result word without a command");

	// compare results must not be overwritten by a second word before execution
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second word taken during compare");
`endif

endmodule

`default_nettype wire
